/* design/sfr_pkg.sv */
// Shared types and constants for the status frame receiver.
package sfr_pkg;

    // Frame byte values
    localparam logic [7:0] HDR0_BYTE      = 8'hFF;
    localparam logic [7:0] HDR1_BYTE      = 8'h55;
    localparam logic [7:0] LEN_BYTE       = 8'h02;
    localparam logic [7:0] CMD_STATUS     = 8'h01;
    localparam logic [7:0] CMD_STATUS_ALT = 8'h0B;

    // Data codes carried by a good frame
    localparam logic [7:0] DATA_EVENT_MAX = 8'h07;
    localparam logic [7:0] DATA_CHG_ON    = 8'h08;
    localparam logic [7:0] DATA_CHG_OFF   = 8'h09;
    localparam logic [7:0] DATA_POWER_ON  = 8'h10;

    // Position of the next byte within the frame; idle ignores the burst
    typedef enum logic [2:0] {
        POS_HDR0 = 3'd0,
        POS_HDR1 = 3'd1,
        POS_LEN  = 3'd2,
        POS_CMD  = 3'd3,
        POS_DATA = 3'd4,
        POS_CHK  = 3'd5,
        POS_IDLE = 3'd6
    } pos_t;

    // Input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_start;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic       frame_ok;
        logic       frame_bad;
        logic       event_valid;
        logic [2:0] event_code;
        logic       charging;
        logic       powered_on;
    } out_beat_t;

endpackage

/* design/status_frame_receiver_core.sv */
// Top level of the status frame receiver: input register, parser, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_valid / s_ready  | s_data  (sfr_pkg::in_beat_t)
//  m_      | out       | m_valid / m_ready  | m_data  (sfr_pkg::out_beat_t)
//
// One result beat per input beat, one beat per cycle sustained while m_ready stays high.
// A beat passes through the input register, then the parser feeds the result register.
// Reset (aresetn low, synchronous) empties both registers and sets the parser idle.
// A stalled result holds; the input register still takes one more beat meanwhile.
module status_frame_receiver_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sfr_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sfr_pkg::out_beat_t m_data
);

    logic               in_valid_reg;
    sfr_pkg::in_beat_t  in_data_reg;
    logic               out_valid_reg;
    sfr_pkg::out_beat_t out_data_reg;
    sfr_pkg::out_beat_t result_next;
    logic               advance;

    // Head moves to the result register when that register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Parser
    sfr_frame_chk u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .beat_in  (in_data_reg),
        .beat_out (result_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // a frame is never both passed and failed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.frame_ok && m_data.frame_bad))
        else $error("frame_ok and frame_bad both set");

    // events only come from a passed frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_valid) |-> m_data.frame_ok)
        else $error("event without a good frame");

    // event code is zero when no event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.event_valid) |-> (m_data.event_code == 3'd0))
        else $error("stray event code");

    // a beat in the input register moves on once the result side frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("head beat not advanced");
`endif

endmodule

/* design/sfr_frame_chk.sv */
// Frame parser: position, checksum and flag state with per-byte result logic.
module sfr_frame_chk (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  sfr_pkg::in_beat_t beat_in,
    output sfr_pkg::out_beat_t beat_out
);

    sfr_pkg::pos_t pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    data_reg, data_next;
    logic          chg_reg, chg_next;
    logic          pwr_reg, pwr_next;

    sfr_pkg::pos_t pos_eff;
    logic [7:0]    sum_eff;
    logic [7:0]    chk_sum;
    logic [7:0]    b;

    // State registers, advanced once per byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= sfr_pkg::POS_IDLE;
            sum_reg  <= 8'h00;
            data_reg <= 8'h00;
            chg_reg  <= 1'b0;
            pwr_reg  <= 1'b0;
        end else if (step_en) begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            data_reg <= data_next;
            chg_reg  <= chg_next;
            pwr_reg  <= pwr_next;
        end
    end

    // Next state and result for the byte at the head
    always_comb begin
        b        = beat_in.rx_byte;
        pos_eff  = beat_in.burst_start ? sfr_pkg::POS_HDR0 : pos_reg;
        sum_eff  = beat_in.burst_start ? 8'h00 : sum_reg;
        chk_sum  = sum_eff + b;

        pos_next  = pos_eff;
        sum_next  = sum_eff;
        data_next = data_reg;
        chg_next  = chg_reg;
        pwr_next  = pwr_reg;

        beat_out = '0;

        unique case (pos_eff)
            sfr_pkg::POS_HDR0: begin
                if (b == sfr_pkg::HDR0_BYTE) begin
                    pos_next = sfr_pkg::POS_HDR1;
                end else begin
                    beat_out.frame_bad = 1'b1;
                    pos_next = sfr_pkg::POS_IDLE;
                end
            end
            sfr_pkg::POS_HDR1: begin
                if (b == sfr_pkg::HDR1_BYTE) begin
                    pos_next = sfr_pkg::POS_LEN;
                end else begin
                    beat_out.frame_bad = 1'b1;
                    pos_next = sfr_pkg::POS_IDLE;
                end
            end
            sfr_pkg::POS_LEN: begin
                if (b == sfr_pkg::LEN_BYTE) begin
                    sum_next = b;
                    pos_next = sfr_pkg::POS_CMD;
                end else begin
                    beat_out.frame_bad = 1'b1;
                    pos_next = sfr_pkg::POS_IDLE;
                end
            end
            sfr_pkg::POS_CMD: begin
                if (b == sfr_pkg::CMD_STATUS || b == sfr_pkg::CMD_STATUS_ALT) begin
                    sum_next = chk_sum;
                    pos_next = sfr_pkg::POS_DATA;
                end else begin
                    beat_out.frame_bad = 1'b1;
                    pos_next = sfr_pkg::POS_IDLE;
                end
            end
            sfr_pkg::POS_DATA: begin
                data_next = b;
                sum_next  = chk_sum;
                pos_next  = sfr_pkg::POS_CHK;
            end
            sfr_pkg::POS_CHK: begin
                pos_next = sfr_pkg::POS_IDLE;
                if (chk_sum == 8'h00) begin
                    beat_out.frame_ok = 1'b1;
                    if (data_reg <= sfr_pkg::DATA_EVENT_MAX) begin
                        beat_out.event_valid = 1'b1;
                        beat_out.event_code  = data_reg[2:0];
                    end else if (data_reg == sfr_pkg::DATA_CHG_ON) begin
                        chg_next = 1'b1;
                    end else if (data_reg == sfr_pkg::DATA_CHG_OFF) begin
                        chg_next = 1'b0;
                    end else if (data_reg == sfr_pkg::DATA_POWER_ON) begin
                        pwr_next = 1'b1;
                    end
                end else begin
                    beat_out.frame_bad = 1'b1;
                end
            end
            default: begin
                // idle or unused code: ignore the byte
                pos_next = sfr_pkg::POS_IDLE;
            end
        endcase

        beat_out.charging   = chg_next;
        beat_out.powered_on = pwr_next;
    end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the status frame receiver core.
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either channel
    localparam int DRAIN_WAIT  = 8;      // extra wait after the last prediction is consumed
    localparam int NO_CORRUPT  = -1;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_LONG_STALLS
    } rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Predictor state
    pos_t       frame_pos   = POS_IDLE;
    logic [7:0] frame_sum   = '0;
    logic [7:0] frame_data  = '0;
    logic       chg_flag    = 1'b0;
    logic       pwr_flag    = 1'b0;

    out_beat_t  status_expected[$];
    logic       failed      = 1'b0;
    int         beats_left_in_burst = 0;
    int         quiet_cycles = 0;

    // Receiver stall pattern state
    rx_mode_t   rx_mode     = RX_ALWAYS;
    int         mode_left   = 0;
    int         pattern_cnt = 0;
    int         hold_left   = 0;
    logic       hold_high   = 1'b1;

    status_frame_receiver_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Predicts the result beat for one accepted input beat
    function automatic out_beat_t predict_status_byte(input in_beat_t beat);
        out_beat_t  res;
        logic [7:0] total;
        res = '0;
        if (beat.burst_start) begin
            frame_pos = POS_HDR0;
            frame_sum = '0;
        end
        case (frame_pos)
            POS_HDR0: begin
                if (beat.rx_byte == HDR0_BYTE) begin
                    frame_pos = POS_HDR1;
                end else begin
                    res.frame_bad = 1'b1;
                    frame_pos = POS_IDLE;
                end
            end
            POS_HDR1: begin
                if (beat.rx_byte == HDR1_BYTE) begin
                    frame_pos = POS_LEN;
                end else begin
                    res.frame_bad = 1'b1;
                    frame_pos = POS_IDLE;
                end
            end
            POS_LEN: begin
                if (beat.rx_byte == LEN_BYTE) begin
                    frame_sum = beat.rx_byte;
                    frame_pos = POS_CMD;
                end else begin
                    res.frame_bad = 1'b1;
                    frame_pos = POS_IDLE;
                end
            end
            POS_CMD: begin
                if (beat.rx_byte == CMD_STATUS || beat.rx_byte == CMD_STATUS_ALT) begin
                    frame_sum = frame_sum + beat.rx_byte;
                    frame_pos = POS_DATA;
                end else begin
                    res.frame_bad = 1'b1;
                    frame_pos = POS_IDLE;
                end
            end
            POS_DATA: begin
                frame_data = beat.rx_byte;
                frame_sum  = frame_sum + beat.rx_byte;
                frame_pos  = POS_CHK;
            end
            POS_CHK: begin
                frame_pos = POS_IDLE;
                total = frame_sum + beat.rx_byte;
                if (total == 8'h00) begin
                    res.frame_ok = 1'b1;
                    if (frame_data <= DATA_EVENT_MAX) begin
                        res.event_valid = 1'b1;
                        res.event_code  = frame_data[2:0];
                    end else if (frame_data == DATA_CHG_ON) begin
                        chg_flag = 1'b1;
                    end else if (frame_data == DATA_CHG_OFF) begin
                        chg_flag = 1'b0;
                    end else if (frame_data == DATA_POWER_ON) begin
                        pwr_flag = 1'b1;
                    end
                end else begin
                    res.frame_bad = 1'b1;
                end
            end
            default: begin
                frame_pos = POS_IDLE;
            end
        endcase
        res.charging   = chg_flag;
        res.powered_on = pwr_flag;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Sends one beat; the sender works in bursts with random gaps between them
    task automatic send_beat(input logic [7:0] rx_byte, input logic burst_start);
        in_beat_t beat;
        int       gap;
        beat.rx_byte     = rx_byte;
        beat.burst_start = burst_start;
        if (beats_left_in_burst == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            beats_left_in_burst = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        beats_left_in_burst--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        status_expected.push_back(predict_status_byte(beat));
    endtask

    // Sends the first frame_len bytes of a frame, optionally with one byte
    // spoilt, followed by tail_len stray bytes in the same burst
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] data,
                              input int corrupt_at, input int frame_len, input int tail_len);
        logic [7:0] frame_bytes[6];
        logic [7:0] sum;
        sum = LEN_BYTE + cmd + data;
        frame_bytes[0] = HDR0_BYTE;
        frame_bytes[1] = HDR1_BYTE;
        frame_bytes[2] = LEN_BYTE;
        frame_bytes[3] = cmd;
        frame_bytes[4] = data;
        frame_bytes[5] = -sum;
        if (corrupt_at >= 0)
            frame_bytes[corrupt_at] = frame_bytes[corrupt_at] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < frame_len; i++)
            send_beat(frame_bytes[i], i == 0);
        for (int i = 0; i < tail_len; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Bytes that arrive while idle, outside any burst
    task automatic test_outside_burst();
        send_beat(HDR0_BYTE, 1'b0);
        send_beat(8'h00, 1'b0);
    endtask

    // Good frames with both commands, flag update and top event code
    task automatic test_good_frames();
        send_frame(CMD_STATUS, DATA_CHG_ON, NO_CORRUPT, 6, 0);
        send_frame(CMD_STATUS_ALT, DATA_EVENT_MAX, NO_CORRUPT, 6, 1);
    endtask

    // A new burst drops a partial frame
    task automatic test_restart_mid_frame();
        send_frame(CMD_STATUS, 8'h00, NO_CORRUPT, 2, 0);
        send_frame(CMD_STATUS_ALT, DATA_POWER_ON, NO_CORRUPT, 6, 0);
    endtask

    // Header mismatch ignores the rest of the burst; bad checksum
    task automatic test_bad_frames();
        send_beat(8'h00, 1'b1);
        send_beat(HDR0_BYTE, 1'b0);
        send_frame(CMD_STATUS, DATA_CHG_OFF, 5, 6, 0);
    endtask

    // Mostly well-formed frames with random content, some spoilt or cut short
    task automatic test_random_frames(input int n_frames);
        logic [7:0] cmd;
        logic [7:0] data;
        int         pick;
        int         corrupt_at;
        int         frame_len;
        int         tail_len;
        for (int f = 0; f < n_frames; f++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                data = 8'($urandom_range(0, 7));
            else if (pick < 55)
                data = DATA_CHG_ON;
            else if (pick < 70)
                data = DATA_CHG_OFF;
            else if (pick < 80)
                data = DATA_POWER_ON;
            else
                data = 8'($urandom_range(0, 255));
            cmd        = $urandom_range(0, 1) ? CMD_STATUS_ALT : CMD_STATUS;
            corrupt_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : NO_CORRUPT;
            frame_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
            tail_len   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            send_frame(cmd, data, corrupt_at, frame_len, tail_len);
        end
    endtask

    // Random bytes with random burst starts
    task automatic test_random_noise(input int n_beats);
        for (int i = 0; i < n_beats; i++)
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
    endtask

    // Receiver stall pattern: mode changes every so often
    always @(posedge aclk) begin : receiver_stall
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            RX_PATTERN: begin
                pattern_cnt++;
                m_ready <= (pattern_cnt % 5) < 3;
            end
            default: begin
                if (hold_left == 0) begin
                    hold_high = !hold_high;
                    hold_left = hold_high ? $urandom_range(1, 12) : $urandom_range(5, 30);
                end else begin
                    hold_left--;
                end
                m_ready <= hold_high;
            end
        endcase
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_expected.size() == 0) begin
                $error("result beat arrived with no prediction pending");
                failed = 1'b1;
            end else begin
                want = status_expected.pop_front();
                check_field("frame_ok",    want.frame_ok,    m_data.frame_ok);
                check_field("frame_bad",   want.frame_bad,   m_data.frame_bad);
                check_field("event_valid", want.event_valid, m_data.event_valid);
                check_field("event_code",  want.event_code,  m_data.event_code);
                check_field("charging",    want.charging,    m_data.charging);
                check_field("powered_on",  want.powered_on,  m_data.powered_on);
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_outside_burst();
        test_good_frames();
        test_restart_mid_frame();
        test_bad_frames();
        test_random_frames(75);
        test_random_noise(80);
        test_random_frames(10);

        s_valid <= 1'b0;
        while (status_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
